>>> src/cvdc_pkg.sv
// Shared types, constants and the calibration table for the voltage to DAC code converter.
// No dependencies.
`timescale 1ns / 1ps

package cvdc_pkg;

    localparam int TABLE_POINTS = 101;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int IDX_CAP_INT  = TABLE_POINTS - 2;

    localparam int REQ_W   = 15;
    localparam int OFF_W   = 16;
    localparam int ROM_W   = 14;
    localparam int CLAMP_W = 14;
    localparam int BIAS_W  = 11;
    localparam int MODE_W  = 3;
    localparam int DAC_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic signed [OFF_W-1:0] ZERO_OFFSET_MV = 16'sd5000;

    // Divide by 100 through a reciprocal, exact for magnitudes below 43690.
    localparam int               DIV100_SHIFT = 21;
    localparam logic [REQ_W-1:0] DIV100_MUL   = 15'd20972;
    localparam int               DIV100_PW    = 2 * REQ_W;
    localparam int               QUO_W        = DIV100_PW - DIV100_SHIFT;
    localparam logic [QUO_W-1:0] IDX_CAP      = QUO_W'(IDX_CAP_INT);

    // Calibrated voltage in units of 0.01 mV.
    localparam int               S_W      = 26;
    localparam int               PROD_W   = 31;
    localparam logic signed [S_W-1:0] S_HUNDRED = 26'sd100;

    // Code mapping: code = num / 1600000 with num = diff * 4095 + 3276000000.
    localparam int                    NUM_W     = 36;
    localparam logic signed [NUM_W-1:0] CODE_HALF = 36'sd3276000000;
    localparam logic signed [NUM_W-1:0] CODE_TOP  = 36'sd6553600000;
    localparam int                    PRE_SHIFT = 9;
    localparam int                    NSH_W     = 24;
    localparam int                    CODE_SHIFT = 36;
    localparam int                    CMUL_W    = 25;
    localparam logic [CMUL_W-1:0]     CODE_MUL  = 25'd21990233;
    localparam int                    QPROD_W   = NSH_W + CMUL_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_CAL_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL   = 3'd5;

    localparam logic [MODE_W-1:0] DRV_MODE1 = 3'd1;
    localparam logic [MODE_W-1:0] DRV_MODE2 = 3'd2;
    localparam logic [MODE_W-1:0] DRV_MODE3 = 3'd3;
    localparam logic [MODE_W-1:0] DRV_MODE4 = 3'd4;
    localparam logic [MODE_W-1:0] DRV_MODE6 = 3'd6;

    localparam logic signed [ROM_W-1:0] CAL_ROM [TABLE_POINTS] = '{
        -14'sd4879, -14'sd4774, -14'sd4672, -14'sd4568, -14'sd4468,
        -14'sd4367, -14'sd4266, -14'sd4165, -14'sd4062, -14'sd3962,
        -14'sd3860, -14'sd3757, -14'sd3654, -14'sd3551, -14'sd3452,
        -14'sd3352, -14'sd3252, -14'sd3149, -14'sd3047, -14'sd2947,
        -14'sd2846, -14'sd2746, -14'sd2645, -14'sd2544, -14'sd2442,
        -14'sd2342, -14'sd2244, -14'sd2139, -14'sd2036, -14'sd1935,
        -14'sd1831, -14'sd1730, -14'sd1629, -14'sd1527, -14'sd1423,
        -14'sd1319, -14'sd1220, -14'sd1111, -14'sd1012, -14'sd904,
        -14'sd808,  -14'sd706,  -14'sd598,  -14'sd506,  -14'sd404,
        -14'sd316,  -14'sd223,  -14'sd121,  -14'sd51,   14'sd10,
        14'sd67,    14'sd141,   14'sd242,   14'sd344,   14'sd445,
        14'sd547,   14'sd648,   14'sd749,   14'sd851,   14'sd951,
        14'sd1052,  14'sd1154,  14'sd1255,  14'sd1356,  14'sd1456,
        14'sd1558,  14'sd1659,  14'sd1760,  14'sd1862,  14'sd1963,
        14'sd2065,  14'sd2165,  14'sd2267,  14'sd2368,  14'sd2467,
        14'sd2569,  14'sd2667,  14'sd2767,  14'sd2869,  14'sd2970,
        14'sd3071,  14'sd3173,  14'sd3276,  14'sd3376,  14'sd3479,
        14'sd3578,  14'sd3676,  14'sd3778,  14'sd3880,  14'sd3983,
        14'sd4082,  14'sd4184,  14'sd4288,  14'sd4386,  14'sd4490,
        14'sd4590,  14'sd4690,  14'sd4792,  14'sd4892,  14'sd4998,
        14'sd5094
    };

    typedef struct packed {
        logic                       cal_en;
        logic signed [CLAMP_W-1:0]  clamp_max;
        logic signed [CLAMP_W-1:0]  clamp_min;
        logic signed [BIAS_W-1:0]   bias;
        logic [MODE_W-1:0]          mode;
        logic                       channel;
    } cvdc_cfg_t;

    typedef struct packed {
        logic                       cal;
        logic [IDX_W-1:0]           idx;
        logic signed [OFF_W-1:0]    seg_mv;
        logic signed [REQ_W-1:0]    mv;
    } cvdc_entry_t;

endpackage

>>> src/calibrated_voltage_to_dac_code.sv
// Calibrated voltage to DAC code converter, top level with configuration registers.
// Path to done: front register, queue, back registers b1 and b2, output register.
// Throughput: one request per cycle; the converter pipeline retires each queued entry
// the cycle after it lands, so busy stays low and the receiver cannot stall.
// Reset: rst_n clears configuration to defaults and empties queue and pipeline.
// Depends on cvdc_pkg, cvdc_front, cvdc_queue, cvdc_back.
`timescale 1ns / 1ps

module calibrated_voltage_to_dac_code (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [cvdc_pkg::REQ_W-1:0]      request_mv,
    output logic                                   done,
    output logic [cvdc_pkg::DAC_W-1:0]             dac_code,
    output logic                                   dac_channel,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cvdc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cvdc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import cvdc_pkg::*;

    cvdc_cfg_t   cfg_reg, cfg_next;
    logic        push;
    cvdc_entry_t push_entry;
    logic        pop;
    logic        head_valid;
    cvdc_entry_t head_entry;
    logic        almost_full;

    assign cfg_ready = 1'b1;
    assign busy      = almost_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CAL_EN:    cfg_next.cal_en    = cfg_data[0];
                REG_CLAMP_MAX: cfg_next.clamp_max = cfg_data[CLAMP_W-1:0];
                REG_CLAMP_MIN: cfg_next.clamp_min = cfg_data[CLAMP_W-1:0];
                REG_BIAS:      cfg_next.bias      = cfg_data[BIAS_W-1:0];
                REG_MODE:      cfg_next.mode      = cfg_data[MODE_W-1:0];
                REG_CHANNEL:   cfg_next.channel   = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_en    <= 1'b1;
            cfg_reg.clamp_max <= 14'sd8000;
            cfg_reg.clamp_min <= -14'sd8000;
            cfg_reg.bias      <= '0;
            cfg_reg.mode      <= '0;
            cfg_reg.channel   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cvdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request_mv (request_mv),
        .cfg        (cfg_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    cvdc_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_entry  (push_entry),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .almost_full (almost_full)
    );

    cvdc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .cfg         (cfg_reg),
        .pop         (pop),
        .done        (done),
        .dac_code    (dac_code),
        .dac_channel (dac_channel)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ##4 done)
        else $error("queued request produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(push, 4))
        else $error("result without a queued request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && busy) |=> !push)
        else $error("request taken while busy");

endmodule

>>> src/cvdc_front.sv
// Front end: takes requests, drops those outside the output modes, finds the table segment.
// Depends on cvdc_pkg.
`timescale 1ns / 1ps

module cvdc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [cvdc_pkg::REQ_W-1:0] request_mv,
    input  cvdc_pkg::cvdc_cfg_t               cfg,
    output logic                              push,
    output cvdc_pkg::cvdc_entry_t             push_entry
);
    import cvdc_pkg::*;

    logic                    accept;
    logic                    mode_ok;
    logic signed [OFF_W-1:0] off;
    logic [REQ_W-1:0]        mag;
    logic [DIV100_PW-1:0]    quo_prod;

    logic                    f_valid_reg, f_valid_next;
    logic                    f_cal_reg;
    logic signed [OFF_W-1:0] f_off_reg;
    logic signed [REQ_W-1:0] f_mv_reg;
    logic [QUO_W-1:0]        f_quo_reg;

    logic [IDX_W-1:0]        idx;
    logic [OFF_W-1:0]        idx_mv;

    always_comb
    begin
        mode_ok = cfg.mode inside {DRV_MODE1, DRV_MODE2, DRV_MODE3, DRV_MODE4, DRV_MODE6};
        accept  = start && !busy;
        off     = OFF_W'(request_mv) + ZERO_OFFSET_MV;
        mag     = off[OFF_W-1] ? REQ_W'(-off) : off[REQ_W-1:0];
        quo_prod = DIV100_PW'(mag) * DIV100_PW'(DIV100_MUL);
        f_valid_next = accept && mode_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_cal_reg <= cfg.cal_en;
            f_off_reg <= off;
            f_mv_reg  <= request_mv;
            f_quo_reg <= quo_prod[DIV100_PW-1:DIV100_SHIFT];
        end
    end

    // Cap the segment at the last pair and keep the distance from its left point.
    always_comb
    begin
        idx    = (f_quo_reg > IDX_CAP) ? IDX_W'(IDX_CAP) : f_quo_reg[IDX_W-1:0];
        idx_mv = OFF_W'(idx) * OFF_W'(100);
        push   = f_valid_reg;
        push_entry.cal    = f_cal_reg;
        push_entry.idx    = idx;
        push_entry.seg_mv = f_off_reg - $signed(idx_mv);
        push_entry.mv     = f_mv_reg;
    end

endmodule

>>> src/cvdc_queue.sv
// Short FIFO between the front end and the converter pipeline.
// Depends on cvdc_pkg.
`timescale 1ns / 1ps

module cvdc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cvdc_pkg::cvdc_entry_t push_entry,
    input  logic                  pop,
    output logic                  head_valid,
    output cvdc_pkg::cvdc_entry_t head_entry,
    output logic                  almost_full
);
    import cvdc_pkg::*;

    cvdc_entry_t       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    always_comb
    begin
        head_valid  = (count_reg != '0);
        head_entry  = mem_reg[rd_ptr_reg];
        // Keep one slot for the item still held in the front stage.
        almost_full = (count_reg >= QCNT_W'(QDEPTH - 1));
        do_pop      = pop && head_valid;
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !do_pop && (count_reg == QCNT_W'(QDEPTH))))
        else $error("queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a transfer");

endmodule

>>> src/cvdc_back.sv
// Converter pipeline: table interpolation, clamp, bias and DAC code mapping.
// Depends on cvdc_pkg.
`timescale 1ns / 1ps

module cvdc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  cvdc_pkg::cvdc_entry_t      head_entry,
    input  cvdc_pkg::cvdc_cfg_t        cfg,
    output logic                       pop,
    output logic                       done,
    output logic [cvdc_pkg::DAC_W-1:0] dac_code,
    output logic                       dac_channel
);
    import cvdc_pkg::*;

    logic signed [ROM_W-1:0]   rom_a;
    logic signed [ROM_W-1:0]   rom_b;
    logic signed [ROM_W:0]     slope;
    logic signed [PROD_W-1:0]  seg_prod;
    logic signed [S_W-1:0]     s_next;

    logic                      b1_valid_reg;
    logic signed [S_W-1:0]     b1_s_reg;

    logic signed [S_W-1:0]     hi;
    logic signed [S_W-1:0]     lo;
    logic signed [S_W-1:0]     s_clamped;
    logic signed [S_W-1:0]     diff;
    logic signed [NUM_W-1:0]   num;

    logic                      b2_valid_reg;
    logic                      b2_sat_lo_reg, b2_sat_lo_next;
    logic                      b2_sat_hi_reg, b2_sat_hi_next;
    logic [NSH_W-1:0]          b2_nsh_reg;

    logic [QPROD_W-1:0]        code_prod;
    logic [DAC_W-1:0]          code_next;

    logic                      done_reg;
    logic [DAC_W-1:0]          code_reg;

    // Stage 1: inter- or extrapolate on the selected segment, or scale mv.
    always_comb
    begin
        pop      = head_valid;
        rom_a    = CAL_ROM[head_entry.idx];
        rom_b    = CAL_ROM[head_entry.idx + 1'b1];
        slope    = (ROM_W + 1)'(rom_b) - (ROM_W + 1)'(rom_a);
        seg_prod = PROD_W'(slope) * PROD_W'(head_entry.seg_mv);
        if (head_entry.cal)
        begin
            s_next = S_W'(rom_a) * S_HUNDRED + S_W'(seg_prod);
        end
        else
        begin
            s_next = S_W'(head_entry.mv) * S_HUNDRED;
        end
    end

    // Stage 2: clamp, max first, then offset and scale.
    always_comb
    begin
        hi = S_W'(cfg.clamp_max) * S_HUNDRED;
        lo = S_W'(cfg.clamp_min) * S_HUNDRED;
        if (b1_s_reg > hi)
        begin
            s_clamped = hi;
        end
        else if (b1_s_reg < lo)
        begin
            s_clamped = lo;
        end
        else
        begin
            s_clamped = b1_s_reg;
        end
        diff = S_W'(cfg.bias) * S_HUNDRED - s_clamped;
        num  = (NUM_W'(diff) <<< DAC_W) - NUM_W'(diff) + CODE_HALF;
        b2_sat_lo_next = num[NUM_W-1];
        b2_sat_hi_next = !num[NUM_W-1] && (num >= CODE_TOP);
    end

    // Stage 3: divide by 3125 through a reciprocal and saturate.
    always_comb
    begin
        code_prod = QPROD_W'(b2_nsh_reg) * QPROD_W'(CODE_MUL);
        if (b2_sat_lo_reg)
        begin
            code_next = '0;
        end
        else if (b2_sat_hi_reg)
        begin
            code_next = '1;
        end
        else
        begin
            code_next = code_prod[CODE_SHIFT+DAC_W-1:CODE_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= head_valid;
            b2_valid_reg <= b1_valid_reg;
            done_reg     <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_s_reg      <= s_next;
        b2_sat_lo_reg <= b2_sat_lo_next;
        b2_sat_hi_reg <= b2_sat_hi_next;
        b2_nsh_reg    <= num[PRE_SHIFT+NSH_W-1:PRE_SHIFT];
        code_reg      <= code_next;
    end

    assign done        = done_reg;
    assign dac_code    = code_reg;
    assign dac_channel = cfg.channel;

    assert property (@(posedge clk) disable iff (!rst_n)
        (b2_valid_reg && b2_sat_hi_reg) |=> (dac_code == '1))
        else $error("high saturation lost");

endmodule
